[rtl/bmp_pkg.sv]
`timescale 1ns / 1ps

package bmp_pkg;

	// field widths
	localparam int N_W   = 12;
	localparam int VAL_W = 30;

	// factorial table
	localparam int unsigned TABLE_DEPTH = 4096;
	localparam int ADDR_W = $clog2(TABLE_DEPTH);

	// modulus and fermat exponent
	localparam logic [VAL_W-1:0] PRIME      = 30'd1000000007;
	localparam logic [VAL_W-1:0] FERMAT_EXP = VAL_W'(PRIME - 30'd2);
	localparam int EXP_TOP = $clog2(int'(FERMAT_EXP) + 1) - 1;
	localparam int EBIT_W  = $clog2(EXP_TOP + 1);

	// barrett reduction for products below 2^60
	localparam logic [63:0] BARRETT_M64 = (64'd1 << 60) / 64'(PRIME);
	localparam logic [30:0] BARRETT_M   = BARRETT_M64[30:0];
	localparam logic [31:0] PRIME_X1    = 32'(PRIME);
	localparam logic [31:0] PRIME_X2    = 32'(PRIME) << 1;

	// microprogram addresses
	localparam int PC_W = 4;
	localparam logic [PC_W-1:0] PC_BUILD    = PC_W'(0);
	localparam logic [PC_W-1:0] PC_B_WRITE  = PC_W'(1);
	localparam logic [PC_W-1:0] PC_B_INC    = PC_W'(2);
	localparam logic [PC_W-1:0] PC_B_MUL    = PC_W'(3);
	localparam logic [PC_W-1:0] PC_B_DONE   = PC_W'(4);
	localparam logic [PC_W-1:0] PC_QUERY    = PC_W'(5);
	localparam logic [PC_W-1:0] PC_Q_RD_NR  = PC_W'(6);
	localparam logic [PC_W-1:0] PC_Q_DENOM  = PC_W'(7);
	localparam logic [PC_W-1:0] PC_Q_KEEP_N = PC_W'(8);
	localparam logic [PC_W-1:0] PC_Q_INIT   = PC_W'(9);
	localparam logic [PC_W-1:0] PC_Q_SQUARE = PC_W'(10);
	localparam logic [PC_W-1:0] PC_Q_TIMES  = PC_W'(11);
	localparam logic [PC_W-1:0] PC_Q_STEP   = PC_W'(12);
	localparam logic [PC_W-1:0] PC_Q_FINAL  = PC_W'(13);
	localparam logic [PC_W-1:0] PC_EMIT     = PC_W'(14);
	localparam logic [PC_W-1:0] PC_ZERO     = PC_W'(15);

	typedef enum logic [3:0] {
		OP_NOP,
		OP_SET_ONE,
		OP_WRITE,
		OP_INC,
		OP_MUL,
		OP_MOVE,
		OP_EXP_INIT,
		OP_DEC,
		OP_ZERO,
		OP_EMIT,
		OP_FINISH
	} op_t;

	typedef enum logic [2:0] {
		SRC_ACC,
		SRC_BASE,
		SRC_TMP,
		SRC_IDX,
		SRC_RD
	} src_t;

	typedef enum logic [1:0] {
		DST_ACC,
		DST_BASE,
		DST_TMP
	} dst_t;

	typedef enum logic [1:0] {
		ADDR_N,
		ADDR_R,
		ADDR_NR
	} addr_sel_t;

	typedef enum logic [2:0] {
		COND_NONE,
		COND_ALWAYS,
		COND_IDX_LAST,
		COND_EBIT_CLEAR,
		COND_EBIT_NONZERO
	} cond_t;

	// one microcode word
	typedef struct packed {
		op_t             op;
		src_t            src_a;
		src_t            src_b;
		dst_t            dst;
		logic            rd_en;
		addr_sel_t       rd_addr;
		cond_t           cond;
		logic [PC_W-1:0] target;
	} ctrl_t;

	// sequencer to datapath
	typedef struct packed {
		ctrl_t word;
		logic  active;
		logic  commit;
		logic  mul_start;
	} seq_ctrl_t;

	// datapath to sequencer
	typedef struct packed {
		logic idx_last;
		logic ebit_clear;
		logic ebit_nonzero;
		logic mul_done;
		logic out_free;
	} status_t;

	function automatic ctrl_t cw(
		input op_t             op,
		input src_t            src_a,
		input src_t            src_b,
		input dst_t            dst,
		input logic            rd_en,
		input addr_sel_t       rd_addr,
		input cond_t           cond,
		input logic [PC_W-1:0] target
	);
		ctrl_t w;
		w.op      = op;
		w.src_a   = src_a;
		w.src_b   = src_b;
		w.dst     = dst;
		w.rd_en   = rd_en;
		w.rd_addr = rd_addr;
		w.cond    = cond;
		w.target  = target;
		return w;
	endfunction

	// control store: table build, then query with one fermat inversion
	function automatic ctrl_t micro_rom(input logic [PC_W-1:0] pc);
		ctrl_t w;
		w = cw(OP_NOP, SRC_ACC, SRC_ACC, DST_ACC, 1'b0, ADDR_N, COND_NONE, PC_BUILD);
		unique case (pc)
			PC_BUILD:    w = cw(OP_SET_ONE, SRC_ACC, SRC_ACC, DST_ACC, 1'b0, ADDR_N,
				COND_NONE, PC_BUILD);
			PC_B_WRITE:  w = cw(OP_WRITE, SRC_ACC, SRC_ACC, DST_ACC, 1'b0, ADDR_N,
				COND_IDX_LAST, PC_B_DONE);
			PC_B_INC:    w = cw(OP_INC, SRC_ACC, SRC_ACC, DST_ACC, 1'b0, ADDR_N,
				COND_NONE, PC_BUILD);
			PC_B_MUL:    w = cw(OP_MUL, SRC_ACC, SRC_IDX, DST_ACC, 1'b0, ADDR_N,
				COND_ALWAYS, PC_B_WRITE);
			PC_B_DONE:   w = cw(OP_FINISH, SRC_ACC, SRC_ACC, DST_ACC, 1'b0, ADDR_N,
				COND_NONE, PC_BUILD);
			PC_QUERY:    w = cw(OP_NOP, SRC_ACC, SRC_ACC, DST_ACC, 1'b1, ADDR_R,
				COND_NONE, PC_BUILD);
			PC_Q_RD_NR:  w = cw(OP_MOVE, SRC_RD, SRC_ACC, DST_TMP, 1'b1, ADDR_NR,
				COND_NONE, PC_BUILD);
			PC_Q_DENOM:  w = cw(OP_MUL, SRC_RD, SRC_TMP, DST_BASE, 1'b1, ADDR_N,
				COND_NONE, PC_BUILD);
			PC_Q_KEEP_N: w = cw(OP_MOVE, SRC_RD, SRC_ACC, DST_TMP, 1'b0, ADDR_N,
				COND_NONE, PC_BUILD);
			PC_Q_INIT:   w = cw(OP_EXP_INIT, SRC_ACC, SRC_ACC, DST_ACC, 1'b0, ADDR_N,
				COND_NONE, PC_BUILD);
			PC_Q_SQUARE: w = cw(OP_MUL, SRC_ACC, SRC_ACC, DST_ACC, 1'b0, ADDR_N,
				COND_EBIT_CLEAR, PC_Q_STEP);
			PC_Q_TIMES:  w = cw(OP_MUL, SRC_ACC, SRC_BASE, DST_ACC, 1'b0, ADDR_N,
				COND_NONE, PC_BUILD);
			PC_Q_STEP:   w = cw(OP_DEC, SRC_ACC, SRC_ACC, DST_ACC, 1'b0, ADDR_N,
				COND_EBIT_NONZERO, PC_Q_SQUARE);
			PC_Q_FINAL:  w = cw(OP_MUL, SRC_ACC, SRC_TMP, DST_ACC, 1'b0, ADDR_N,
				COND_NONE, PC_BUILD);
			PC_EMIT:     w = cw(OP_EMIT, SRC_ACC, SRC_ACC, DST_ACC, 1'b0, ADDR_N,
				COND_NONE, PC_BUILD);
			PC_ZERO:     w = cw(OP_ZERO, SRC_ACC, SRC_ACC, DST_ACC, 1'b0, ADDR_N,
				COND_ALWAYS, PC_EMIT);
			default:     w = cw(OP_FINISH, SRC_ACC, SRC_ACC, DST_ACC, 1'b0, ADDR_N,
				COND_NONE, PC_BUILD);
		endcase
		return w;
	endfunction

endpackage

[rtl/bmp_if.sv]
`timescale 1ns / 1ps

// input item channel
interface bmp_item_if;
	logic                    valid;
	logic                    ready;
	logic                    action;
	logic [bmp_pkg::N_W-1:0] n_value;
	logic [bmp_pkg::N_W-1:0] r_value;

	modport source(output valid, output action, output n_value, output r_value, input ready);
	modport sink(input valid, input action, input n_value, input r_value, output ready);
endinterface

// result channel
interface bmp_result_if;
	logic                      valid;
	logic                      ready;
	logic [bmp_pkg::VAL_W-1:0] binomial;

	modport source(output valid, output binomial, input ready);
	modport sink(input valid, input binomial, output ready);
endinterface

[rtl/binomial_mod_prime_unit.sv]
`timescale 1ns / 1ps

// Binomial coefficients modulo 1000000007. An item with action 0 builds the
// factorial table (4096 entries) and gives no result; each entry waits on
// the modular multiplier for the chain table[i] = table[i-1] * i. An item
// with action 1 gives n! / (r! (n-r)!) mod p as one result; the two
// factorials below are multiplied first and inverted together by
// square-and-multiply to p-2, so a query costs 45 dependent multiplications.
// A query with r above n, or n beyond the table, returns 0 without any
// multiplication. One item is in work at a time: a new item is taken once
// the microprogram has finished, even while the last result still waits in
// the output register. A query is only meaningful after a build.
module binomial_mod_prime_unit (
	input  logic         clk,
	input  logic         arst_n,
	bmp_item_if.sink     item,
	bmp_result_if.source result
);
	import bmp_pkg::*;

	seq_ctrl_t ctl;
	status_t   status;
	logic      accept;

	// input transfer
	assign item.ready = !ctl.active;
	assign accept     = item.valid && item.ready;

	bmp_sequencer u_sequencer (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (accept),
		.action  (item.action),
		.n_value (item.n_value),
		.r_value (item.r_value),
		.status  (status),
		.ctl     (ctl)
	);

	bmp_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (accept),
		.n_value      (item.n_value),
		.r_value      (item.r_value),
		.ctl          (ctl),
		.result_ready (result.ready),
		.status       (status),
		.result_valid (result.valid),
		.binomial     (result.binomial)
	);

endmodule

[rtl/bmp_modmul.sv]
`timescale 1ns / 1ps

module bmp_modmul (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [bmp_pkg::VAL_W-1:0] a,
	input  logic [bmp_pkg::VAL_W-1:0] b,
	output logic                      done,
	output logic [bmp_pkg::VAL_W-1:0] product
);
	import bmp_pkg::*;

	logic [4:0]       vld_q;
	logic [59:0]      prod_s1;
	logic [30:0]      q2_s2;
	logic [31:0]      xlo_s2;
	logic [31:0]      xlo_s3;
	logic [31:0]      q3p_s3;
	logic [31:0]      rem_s4;
	logic [VAL_W-1:0] res_s5;
	logic [31:0]      q3p_full;

	// quotient estimate times modulus, only the low word is needed
	assign q3p_full = 32'(q2_s2) * PRIME_X1;

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[3:0], start};
		end
	end

	// barrett pipeline: product, estimate, estimate times p, remainder, correction
	always_ff @(posedge clk) begin
		prod_s1 <= 60'(a) * 60'(b);
		q2_s2   <= 31'((62'(prod_s1[59:29]) * 62'(BARRETT_M)) >> 31);
		xlo_s2  <= prod_s1[31:0];
		xlo_s3  <= xlo_s2;
		q3p_s3  <= q3p_full;
		rem_s4  <= xlo_s3 - q3p_s3;
		if (rem_s4 >= PRIME_X2) begin
			res_s5 <= VAL_W'(rem_s4 - PRIME_X2);
		end else if (rem_s4 >= PRIME_X1) begin
			res_s5 <= VAL_W'(rem_s4 - PRIME_X1);
		end else begin
			res_s5 <= VAL_W'(rem_s4);
		end
	end

	assign done    = vld_q[4];
	assign product = res_s5;

endmodule

[rtl/bmp_sequencer.sv]
`timescale 1ns / 1ps

module bmp_sequencer (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic                    action,
	input  logic [bmp_pkg::N_W-1:0] n_value,
	input  logic [bmp_pkg::N_W-1:0] r_value,
	input  bmp_pkg::status_t        status,
	output bmp_pkg::seq_ctrl_t      ctl
);
	import bmp_pkg::*;

	logic            busy_q;
	logic [PC_W-1:0] pc_q;
	logic            mul_wait_q;
	ctrl_t           word;
	logic            commit;
	logic            taken;
	logic            query_zero;
	logic            mul_start;
	logic [PC_W-1:0] entry_pc;

	// fetch and step completion
	always_comb begin
		word = micro_rom(pc_q);
		unique case (word.op)
			OP_MUL:  commit = busy_q && status.mul_done;
			OP_EMIT: commit = busy_q && status.out_free;
			default: commit = busy_q;
		endcase
	end

	// jump condition
	always_comb begin
		unique case (word.cond)
			COND_ALWAYS:       taken = 1'b1;
			COND_IDX_LAST:     taken = status.idx_last;
			COND_EBIT_CLEAR:   taken = status.ebit_clear;
			COND_EBIT_NONZERO: taken = status.ebit_nonzero;
			default:           taken = 1'b0;
		endcase
	end

	// entry point: r above n or n beyond the table gives zero at once
	assign query_zero = (r_value > n_value) || (32'(n_value) >= 32'(TABLE_DEPTH));
	assign entry_pc   = !action ? PC_BUILD : (query_zero ? PC_ZERO : PC_QUERY);
	assign mul_start  = busy_q && (word.op == OP_MUL) && !mul_wait_q;

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			pc_q       <= PC_BUILD;
			mul_wait_q <= 1'b0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
				pc_q   <= entry_pc;
			end else if (commit) begin
				if (word.op == OP_FINISH || word.op == OP_EMIT) begin
					busy_q <= 1'b0;
				end else begin
					pc_q <= taken ? word.target : pc_q + PC_W'(1);
				end
			end
			if (mul_start) begin
				mul_wait_q <= 1'b1;
			end else if (status.mul_done) begin
				mul_wait_q <= 1'b0;
			end
		end
	end

	assign ctl.word      = word;
	assign ctl.active    = busy_q;
	assign ctl.commit    = commit;
	assign ctl.mul_start = mul_start;

endmodule

[rtl/bmp_datapath.sv]
`timescale 1ns / 1ps

module bmp_datapath (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      load,
	input  logic [bmp_pkg::N_W-1:0]   n_value,
	input  logic [bmp_pkg::N_W-1:0]   r_value,
	input  bmp_pkg::seq_ctrl_t        ctl,
	input  logic                      result_ready,
	output bmp_pkg::status_t          status,
	output logic                      result_valid,
	output logic [bmp_pkg::VAL_W-1:0] binomial
);
	import bmp_pkg::*;

	logic [VAL_W-1:0]  fact_mem [TABLE_DEPTH];
	logic [VAL_W-1:0]  rd_q;
	logic [VAL_W-1:0]  acc_q;
	logic [VAL_W-1:0]  base_q;
	logic [VAL_W-1:0]  tmp_q;
	logic [ADDR_W-1:0] idx_q;
	logic [EBIT_W-1:0] ebit_q;
	logic [N_W-1:0]    n_q;
	logic [N_W-1:0]    r_q;
	logic [N_W-1:0]    nr_q;
	logic              out_valid_q;
	logic [VAL_W-1:0]  binomial_q;
	logic [ADDR_W-1:0] rd_addr;
	logic [VAL_W-1:0]  opnd_a;
	logic [VAL_W-1:0]  opnd_b;
	logic [VAL_W-1:0]  dst_data;
	logic [VAL_W-1:0]  mul_result;
	logic              mul_done;
	logic              out_free;
	logic              emit;

	function automatic logic [VAL_W-1:0] pick(input src_t s);
		logic [VAL_W-1:0] v;
		case (s)
			SRC_ACC:  v = acc_q;
			SRC_BASE: v = base_q;
			SRC_TMP:  v = tmp_q;
			SRC_IDX:  v = VAL_W'(idx_q);
			SRC_RD:   v = rd_q;
			default:  v = acc_q;
		endcase
		return v;
	endfunction

	// operand selection
	always_comb begin
		opnd_a   = pick(ctl.word.src_a);
		opnd_b   = pick(ctl.word.src_b);
		dst_data = (ctl.word.op == OP_MUL) ? mul_result : opnd_a;
	end

	// table read address
	always_comb begin
		case (ctl.word.rd_addr)
			ADDR_R:  rd_addr = ADDR_W'(r_q);
			ADDR_NR: rd_addr = ADDR_W'(nr_q);
			default: rd_addr = ADDR_W'(n_q);
		endcase
	end

	bmp_modmul u_modmul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (ctl.mul_start),
		.a       (opnd_a),
		.b       (opnd_b),
		.done    (mul_done),
		.product (mul_result)
	);

	// factorial table
	always_ff @(posedge clk) begin
		if (ctl.commit && ctl.word.op == OP_WRITE) begin
			fact_mem[idx_q] <= acc_q;
		end
		if (ctl.active && ctl.word.rd_en) begin
			rd_q <= fact_mem[rd_addr];
		end
	end

	// indices of the query
	always_ff @(posedge clk) begin
		if (load) begin
			n_q  <= n_value;
			r_q  <= r_value;
			nr_q <= n_value - r_value;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (ctl.commit) begin
			unique case (ctl.word.op) inside
				OP_SET_ONE: begin
					acc_q <= VAL_W'(1);
					idx_q <= '0;
				end
				OP_INC: begin
					idx_q <= idx_q + ADDR_W'(1);
				end
				OP_MUL, OP_MOVE: begin
					case (ctl.word.dst)
						DST_BASE: base_q <= dst_data;
						DST_TMP:  tmp_q  <= dst_data;
						default:  acc_q  <= dst_data;
					endcase
				end
				OP_EXP_INIT: begin
					acc_q  <= base_q;
					ebit_q <= EBIT_W'(EXP_TOP - 1);
				end
				OP_DEC: begin
					ebit_q <= ebit_q - EBIT_W'(1);
				end
				OP_ZERO: begin
					acc_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	// output register
	assign out_free = !out_valid_q || result_ready;
	assign emit     = ctl.commit && (ctl.word.op == OP_EMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			binomial_q <= acc_q;
		end
	end

	assign status.idx_last     = (idx_q == ADDR_W'(TABLE_DEPTH - 1));
	assign status.ebit_clear   = !FERMAT_EXP[ebit_q];
	assign status.ebit_nonzero = (ebit_q != '0);
	assign status.mul_done     = mul_done;
	assign status.out_free     = out_free;

	assign result_valid = out_valid_q;
	assign binomial     = binomial_q;

endmodule
